/* design/kxbs_pkg.sv */
// Package of the keyed XOR byte scrambler: item types, item kinds and constants.
`timescale 1ns / 1ps
`default_nettype none

package kxbs_pkg;

  // Default geometry of the command-text store
  localparam int unsigned DefSlotCount = 64;
  localparam int unsigned DefTextLen   = 1024;

  // Character clean-up constants
  localparam logic [7:0] CharLimit   = 8'd127;
  localparam logic [7:0] CharPercent = 8'h25;
  localparam logic [7:0] CharDot     = 8'h2E;

  // Item kinds on the input channel
  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_START = 2'd1,
    KIND_DATA  = 2'd2
  } kind_e;

  // Input item
  typedef struct packed {
    kind_e      kind;
    logic [5:0] slot;
    logic [9:0] char_index;
    logic [7:0] text_char;
    logic [7:0] seed;
    logic [7:0] data_byte;
    logic       position_odd;
    logic       message_end;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_item_t;

endpackage

`default_nettype wire

/* design/keyed_xor_byte_scrambler.sv */
// Top level of the keyed XOR byte scrambler: text store, rolling key and output register.
`timescale 1ns / 1ps
`default_nettype none

// Takes one item per clock and returns the result of a data item in the cycle after it is
// accepted, held in an output register; a new item is taken whenever that register is empty
// or is being emptied in the same cycle. Load items write the command-text store
// (SLOT_COUNT x TEXT_LEN bytes, 65536 with the defaults), a block RAM with two registered
// read ports. Every cycle the store is read at the character the next data item will use and
// at the first character of the active slot, so the wrap on a NUL or at the end of the slot
// needs no second access; a load to either of those addresses is forwarded into the read
// data. The store is not cleared after reset: fill a slot before using it.
module keyed_xor_byte_scrambler #(
  parameter int unsigned SLOT_COUNT = kxbs_pkg::DefSlotCount,
  parameter int unsigned TEXT_LEN   = kxbs_pkg::DefTextLen
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // input items
  input  wire logic                in_valid_i,
  output      logic                in_stall_o,
  input  wire kxbs_pkg::in_item_t  in_item_i,
  // result items
  output      logic                out_valid_o,
  input  wire logic                out_stall_i,
  output      kxbs_pkg::out_item_t out_item_o,
  // challenge register write
  input  wire logic                cfg_valid_i,
  output      logic                cfg_ready_o,
  input  wire logic [7:0]          cfg_data_i
);

  localparam int unsigned SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned IDX_W  = $clog2(TEXT_LEN);
  localparam int unsigned POS_W  = $clog2(TEXT_LEN + 1);
  localparam int unsigned ADDR_W = SLOT_W + IDX_W;
  localparam int unsigned DEPTH  = 1 << ADDR_W;

  // Slot numbers reduced modulo SLOT_COUNT, one entry per 6-bit slot code
  logic [SLOT_W-1:0] slot_mod_tbl [64];
  for (genvar v = 0; v < 64; v++) begin : g_slot_tbl
    assign slot_mod_tbl[v] = SLOT_W'(v % SLOT_COUNT);
  end

  // State
  logic [7:0]        chal_q;
  logic [7:0]        key_q, key_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic              out_valid_q, out_valid_d;
  kxbs_pkg::out_item_t out_q, out_d;

  // Text store and its registered read data
  logic [7:0]        text_mem [DEPTH];
  logic [7:0]        rd_cur_q;
  logic [7:0]        rd_first_q;

  logic              in_acc;
  logic [SLOT_W-1:0] item_slot;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_cur_addr;
  logic [ADDR_W-1:0] rd_first_addr;
  logic              wrap;
  logic [7:0]        raw_char;
  logic [7:0]        clean_char;
  logic [7:0]        mix_char;
  logic [POS_W-1:0]  pos_base;

  // Handshakes
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign cfg_ready_o = 1'b1;

  assign item_slot = slot_mod_tbl[in_item_i.slot];

  // Load write into the store
  assign wr_en   = in_acc && (in_item_i.kind == kxbs_pkg::KIND_LOAD)
                   && (32'(in_item_i.char_index) < 32'(TEXT_LEN));
  assign wr_addr = {item_slot, IDX_W'(in_item_i.char_index)};

  // Character for the current data item, wrapping on a NUL or at the end of the slot
  assign wrap       = (pos_q == POS_W'(TEXT_LEN)) || (rd_cur_q == 8'd0);
  assign raw_char   = wrap ? rd_first_q : rd_cur_q;
  assign clean_char = ((raw_char > kxbs_pkg::CharLimit) || (raw_char == kxbs_pkg::CharPercent))
                      ? kxbs_pkg::CharDot : raw_char;
  assign mix_char   = in_item_i.position_odd ? {clean_char[6:0], 1'b0} : clean_char;
  assign pos_base   = wrap ? '0 : pos_q;

  // Next state of key, position, slot and output register
  always_comb begin
    key_d       = key_q;
    pos_d       = pos_q;
    slot_d      = slot_q;
    out_valid_d = out_valid_q & out_stall_i;
    out_d       = out_q;
    if (in_acc) begin
      case (in_item_i.kind)
        kxbs_pkg::KIND_START: begin
          slot_d = item_slot;
          key_d  = chal_q ^ in_item_i.seed;
          pos_d  = '0;
        end
        kxbs_pkg::KIND_DATA: begin
          key_d          = key_q ^ mix_char;
          pos_d          = pos_base + POS_W'(1);
          out_valid_d    = 1'b1;
          out_d.out_byte = in_item_i.data_byte ^ key_d;
          out_d.out_last = in_item_i.message_end;
        end
        default: begin
        end
      endcase
    end
  end

  // Read addresses follow the state of the next cycle
  assign rd_cur_addr   = {slot_d, pos_d[IDX_W-1:0]};
  assign rd_first_addr = {slot_d, IDX_W'(0)};

  // Store: one write, two reads, a same-cycle write forwarded to the read data
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      text_mem[wr_addr] <= in_item_i.text_char;
    end
    rd_cur_q   <= (wr_en && (wr_addr == rd_cur_addr)) ? in_item_i.text_char
                                                      : text_mem[rd_cur_addr];
    rd_first_q <= (wr_en && (wr_addr == rd_first_addr)) ? in_item_i.text_char
                                                        : text_mem[rd_first_addr];
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chal_q      <= '0;
      key_q       <= '0;
      pos_q       <= '0;
      slot_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        chal_q <= cfg_data_i;
      end
      key_q       <= key_d;
      pos_q       <= pos_d;
      slot_q      <= slot_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Checks
  a_no_stall_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> !in_stall_o)
    else $error("input stalled with an empty output register");

  a_data_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_item_i.kind == kxbs_pkg::KIND_DATA))
      |=> (out_valid_o && (out_item_o.out_last == $past(in_item_i.message_end))))
    else $error("data item without its result");

  a_other_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_item_i.kind != kxbs_pkg::KIND_DATA)) |=> !out_valid_o)
    else $error("result from a load or start item");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= POS_W'(TEXT_LEN))
    else $error("text position beyond the slot");

endmodule

`default_nettype wire

/* sim/scramble_checker.sv */
// Checker of the keyed XOR byte scrambler: tracks the text store and key, predicts and compares.
`timescale 1ns / 1ps

module scramble_checker
  import kxbs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  in_item_t   in_item_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  out_item_t  out_item_i,
  input  logic       cfg_valid_i,
  input  logic       cfg_ready_i,
  input  logic [7:0] cfg_data_i,
  output int         fail_count_o,
  output int         pending_o
);

  localparam int unsigned SlotCount = DefSlotCount;
  localparam int unsigned TextLen   = DefTextLen;

  // own copy of the block state
  logic [7:0]  text_mem [SlotCount * TextLen];
  logic [7:0]  roll_key;
  logic [7:0]  challenge;
  int unsigned text_idx;
  int unsigned cur_slot;

  // scrambled bytes still owed by the block, oldest first
  out_item_t   expected_bytes [$];

  // apply one accepted item to the state; a data item queues its scrambled byte
  task automatic predict_scramble(in_item_t it);
    int unsigned base;
    logic [7:0]  ch;
    out_item_t   res;
    case (it.kind)
      KIND_LOAD: begin
        if (it.char_index < TextLen) begin
          text_mem[(it.slot % SlotCount) * TextLen + it.char_index] = it.text_char;
        end
      end
      KIND_START: begin
        cur_slot = it.slot % SlotCount;
        roll_key = challenge ^ it.seed;
        text_idx = 0;
      end
      KIND_DATA: begin
        base = cur_slot * TextLen;
        // wrap to the first character on a NUL or past the end of the slot
        if (text_idx >= TextLen || text_mem[base + text_idx] == 8'd0) text_idx = 0;
        ch = text_mem[base + text_idx];
        if (ch > CharLimit || ch == CharPercent) ch = CharDot;
        roll_key = roll_key ^ (it.position_odd ? {ch[6:0], 1'b0} : ch);
        text_idx++;
        res.out_byte = it.data_byte ^ roll_key;
        res.out_last = it.message_end;
        expected_bytes.push_back(res);
      end
      default: begin
        // unused kind: no effect
      end
    endcase
  endtask

  // sample the channels at each edge
  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_item_t want;
    if (!rst_ni) begin
      roll_key  = '0;
      challenge = '0;
      text_idx  = 0;
      cur_slot  = 0;
      expected_bytes.delete();
      fail_count_o = 0;
    end else begin
      // results first: each is matched against the oldest expectation
      if (out_valid_i && !out_stall_i) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected item: out_byte %h out_last %b", $time,
                   out_item_i.out_byte, out_item_i.out_last);
          fail_count_o++;
        end else begin
          want = expected_bytes.pop_front();
          if (out_item_i.out_byte !== want.out_byte) begin
            $display("%0t: out_byte expected %h actual %h", $time,
                     want.out_byte, out_item_i.out_byte);
            fail_count_o++;
          end
          if (out_item_i.out_last !== want.out_last) begin
            $display("%0t: out_last expected %b actual %b", $time,
                     want.out_last, out_item_i.out_last);
            fail_count_o++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) challenge = cfg_data_i;
      if (in_valid_i && !in_stall_i) predict_scramble(in_item_i);
    end
    pending_o = expected_bytes.size();
  end

endmodule

/* sim/tb_top.sv */
// Testbench top of the keyed XOR byte scrambler: clock, reset, stimulus, stalls and verdict.
`timescale 1ns / 1ps

module tb_top;
  import kxbs_pkg::*;

  localparam int unsigned SlotCount   = DefSlotCount;
  localparam int unsigned TextLen     = DefTextLen;
  localparam int unsigned RandomItems = 900;
  // longest quiet spell of a correct run is a stall run
  localparam int unsigned IdleLimit   = 1000;
  localparam kind_e       KindUnused  = kind_e'(2'd3);

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  in_item_t   in_item   = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_item;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data  = 8'd0;

  int fail_count;
  int pending;

  // length of the written prefix of each slot; its last entry is a NUL unless the slot is full
  int fill_len [SlotCount];
  int burst_left   = 0;
  int sent_count   = 0;
  int result_count = 0;
  int cfg_count    = 0;
  int idle_cycles  = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  keyed_xor_byte_scrambler dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  scramble_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_item_i   (out_item),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // result count and watchdog on cycles where nothing moves
  always @(posedge clk) begin
    if (out_valid && !out_stall) result_count <= result_count + 1;
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IdleLimit) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver stalls in stretches, each with its own density
  initial begin : stall_pattern
    int mode;
    int span;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(4, 40);
      repeat (span) begin
        @(posedge clk);
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 1) == 0);
          default: out_stall <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // text character biased towards the clean-up cases, never NUL
  function automatic logic [7:0] text_byte();
    case ($urandom_range(0, 7))
      0: return CharPercent;
      1: return CharLimit;
      2: return CharLimit + 8'd1;
      3: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h01;
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  // item of the given kind with every field random
  function automatic in_item_t any_item(kind_e k);
    in_item_t it;
    it.kind         = k;
    it.slot         = 6'($urandom);
    it.char_index   = 10'($urandom);
    it.text_char    = 8'($urandom);
    it.seed         = 8'($urandom);
    it.data_byte    = 8'($urandom);
    it.position_odd = 1'($urandom);
    it.message_end  = 1'($urandom);
    return it;
  endfunction

  function automatic int ready_slot();
    int s;
    do s = $urandom_range(0, SlotCount - 1); while (fill_len[s] == 0);
    return s;
  endfunction

  // drive one item in bursts with random gaps; returns at the edge it is taken
  task automatic push_item(in_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    if (it.kind != KindUnused) sent_count++;
  endtask

  task automatic load_char(int slot, int idx, logic [7:0] ch);
    in_item_t it;
    it = any_item(KIND_LOAD);
    it.slot       = 6'(slot);
    it.char_index = 10'(idx);
    it.text_char  = ch;
    push_item(it);
  endtask

  // text of len characters closed by a NUL
  task automatic load_text(int slot, int len);
    for (int i = 0; i <= len; i++) load_char(slot, i, (i == len) ? 8'd0 : text_byte());
    if (len == 0 && fill_len[slot] < 2) begin
      // an empty text moves on to its second entry after the wrap, so that one needs a NUL too
      load_char(slot, 1, 8'd0);
      fill_len[slot] = 2;
    end else if (len + 1 > fill_len[slot]) begin
      fill_len[slot] = len + 1;
    end
  endtask

  task automatic start_msg(int slot, logic [7:0] seed);
    in_item_t it;
    it = any_item(KIND_START);
    it.slot = 6'(slot);
    it.seed = seed;
    push_item(it);
  endtask

  task automatic send_data(logic [7:0] d, logic odd, logic last);
    in_item_t it;
    it = any_item(KIND_DATA);
    it.data_byte    = d;
    it.position_odd = odd;
    it.message_end  = last;
    push_item(it);
  endtask

  // unused kind, or a load that keeps every reachable entry written
  task automatic noise_item();
    int s;
    if ($urandom_range(0, 3) == 0) begin
      push_item(any_item(KindUnused));
    end else begin
      s = ready_slot();
      if (fill_len[s] >= 2 && $urandom_range(0, 1) != 0) begin
        load_char(s, $urandom_range(0, fill_len[s] - 2), 8'($urandom));
      end else begin
        load_char(s, fill_len[s] - 1, (fill_len[s] == TextLen) ? 8'($urandom) : 8'd0);
      end
    end
  endtask

  // mostly well-formed messages; some skip the start, drop or misplace the end mark
  task automatic random_message();
    int   s;
    int   n;
    logic odd;
    if ($urandom_range(0, 9) < 3) begin
      s = $urandom_range(0, SlotCount - 1);
      load_text(s, ($urandom_range(0, 7) == 0) ? $urandom_range(25, 80) : $urandom_range(0, 24));
    end else begin
      s = ready_slot();
    end
    if ($urandom_range(0, 9) != 0) start_msg(s, 8'($urandom));
    n   = $urandom_range(1, 32);
    odd = 1'($urandom);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0) noise_item();
      send_data(8'($urandom), ($urandom_range(0, 9) == 0) ? 1'($urandom) : odd,
                (i == n - 1) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 15) == 0));
      odd = ~odd;
    end
  endtask

  // wait until every owed result is back, plus a margin for the pipeline
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_challenge(logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_count++;
  endtask

  initial begin : stimulus
    logic [7:0] plan [4];
    int         base;
    plan = '{8'h80, 8'h01, 8'hFF, 8'h7F};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    write_challenge(8'hFF);

    // data before any start: slot 0 with the reset key, every clean-up case, NUL wrap
    load_char(0, 0, CharPercent);
    load_char(0, 1, CharLimit + 8'd1);
    load_char(0, 2, CharLimit);
    load_char(0, 3, 8'hFF);
    load_char(0, 4, 8'h01);
    load_char(0, 5, 8'h00);
    fill_len[0] = 6;
    for (int i = 0; i < 7; i++) send_data(i[0] ? 8'hFF : 8'h00, i[0], i == 6);

    // top slot keyed from challenge and seed, data past the end mark, unused kind
    load_char(63, 0, 8'h41);
    load_char(63, 1, 8'h7E);
    load_char(63, 2, 8'h00);
    fill_len[63] = 3;
    start_msg(63, 8'hFF);
    send_data(8'hFF, 1'b0, 1'b0);
    send_data(8'h00, 1'b1, 1'b1);
    push_item(any_item(KindUnused));
    send_data(8'hA5, 1'b0, 1'b0);
    start_msg(0, 8'h00);
    send_data(8'h5A, 1'b1, 1'b1);
    settle();
    write_challenge(8'h00);

    // random messages in phases, a new challenge between phases
    base = sent_count;
    for (int p = 0; p < 6; p++) begin
      while (sent_count < base + (p + 1) * (RandomItems / 6)) random_message();
      settle();
      write_challenge((p < 4) ? plan[p] : 8'($urandom));
    end

    $display("tb: run covered %0d items acted on and %0d results checked", sent_count,
             result_count);
    $display("tb: %0d challenge settings, empty and short texts, messages with no start",
             cfg_count);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* keyed_xor_byte_scrambler.f */
design/kxbs_pkg.sv
design/keyed_xor_byte_scrambler.sv
sim/scramble_checker.sv
sim/tb_top.sv
